### sv/vmrf_pkg.sv
// Shared constants and codes for the virtio MMIO register file.
`timescale 1ns / 1ps
`default_nettype none

package vmrf_pkg;

    localparam int QUEUE_COUNT_DEF        = 8;
    localparam int QUEUE_DEPTH_MAX_DEF    = 16;
    localparam int CONFIG_STORE_BYTES_DEF = 256;

    localparam logic [31:0] MAGIC_WORD   = 32'h7472_6976;
    localparam logic [31:0] VERSION_WORD = 32'd2;

    // request actions
    localparam logic [1:0] ACT_READ       = 2'd0;
    localparam logic [1:0] ACT_WRITE      = 2'd1;
    localparam logic [1:0] ACT_USED       = 2'd2;
    localparam logic [1:0] ACT_CFG_CHANGE = 2'd3;

    // access sizes
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;
    localparam logic [1:0] SZ_NONE = 2'd3;

    // register offsets
    localparam logic [11:0] REG_MAGIC       = 12'h000;
    localparam logic [11:0] REG_VERSION     = 12'h004;
    localparam logic [11:0] REG_DEVICE_ID   = 12'h008;
    localparam logic [11:0] REG_VENDOR_ID   = 12'h00c;
    localparam logic [11:0] REG_FEATURES    = 12'h010;
    localparam logic [11:0] REG_FEAT_SEL    = 12'h014;
    localparam logic [11:0] REG_QUEUE_SEL   = 12'h030;
    localparam logic [11:0] REG_QUEUE_MAX   = 12'h034;
    localparam logic [11:0] REG_QUEUE_NUM   = 12'h038;
    localparam logic [11:0] REG_QUEUE_READY = 12'h044;
    localparam logic [11:0] REG_NOTIFY      = 12'h050;
    localparam logic [11:0] REG_INT_STATUS  = 12'h060;
    localparam logic [11:0] REG_INT_ACK     = 12'h064;
    localparam logic [11:0] REG_STATUS      = 12'h070;
    localparam logic [11:0] REG_DESC_LO     = 12'h080;
    localparam logic [11:0] REG_DESC_HI     = 12'h084;
    localparam logic [11:0] REG_AVAIL_LO    = 12'h090;
    localparam logic [11:0] REG_AVAIL_HI    = 12'h094;
    localparam logic [11:0] REG_USED_LO     = 12'h0a0;
    localparam logic [11:0] REG_USED_HI     = 12'h0a4;
    localparam logic [11:0] CFG_BASE        = 12'h100;

    // configuration register indexes
    localparam logic [2:0] CFG_DEVICE_KIND  = 3'd0;
    localparam logic [2:0] CFG_VENDOR_CODE  = 3'd1;
    localparam logic [2:0] CFG_FEATURE_WORD = 3'd2;
    localparam logic [2:0] CFG_BYTES_USED   = 3'd3;
    localparam logic [2:0] CFG_MANUAL_MASK  = 3'd4;

    localparam logic [15:0] DEVICE_KIND_RST = 16'd2;
    localparam logic [15:0] VENDOR_CODE_RST = 16'hffff;
    localparam logic [8:0]  BYTES_USED_RST  = 9'd8;

endpackage

`default_nettype wire

### sv/virtio_mmio_register_file.sv
// Virtio MMIO version 2 register front end with queue and device config stores.
//
// Requests enter on req_valid/req_stall: a bus read, a bus write, a used
// buffer event or a config change event. Each request yields exactly one
// response on rsp_valid/rsp_stall carrying read data, the interrupt level
// after the request, and a queue notify indication.
// A request is taken in ST_IDLE, when the queue and config memories are read
// into registers; the read-modify-write step then registers its response in
// ST_EXEC. req_stall is high in ST_EXEC, so no new request is taken until
// that step is done. A new request may be taken while a response still
// waits; the step after it holds until the response register is free, so a
// stalled receiver backs up to req_stall.
// Configuration registers are written on cfg_valid/cfg_ready (always ready);
// the user must write them only while the block is idle (not enforced).
// Reset clears selectors, status, interrupts, all queue entries (per-queue
// valid bits) and the config bytes (per-row valid bits); no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module virtio_mmio_register_file #(
    parameter int QUEUE_COUNT        = vmrf_pkg::QUEUE_COUNT_DEF,
    parameter int QUEUE_DEPTH_MAX    = vmrf_pkg::QUEUE_DEPTH_MAX_DEF,
    parameter int CONFIG_STORE_BYTES = vmrf_pkg::CONFIG_STORE_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic [1:0]  action,
    input  wire logic [11:0] offset,
    input  wire logic [31:0] wr_data,
    input  wire logic [1:0]  size_code,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output logic [31:0]      read_data,
    output logic             irq_level,
    output logic             notify_valid,
    output logic [2:0]       notify_queue,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import vmrf_pkg::*;

    localparam int QW   = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam int QSW  = $clog2(QUEUE_DEPTH_MAX + 1);
    localparam int ROWS = (CONFIG_STORE_BYTES + 3) / 4;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [8:0]  STORE_BYTES = 9'(CONFIG_STORE_BYTES);
    localparam logic [31:0] QCOUNT_W    = 32'(QUEUE_COUNT);
    localparam logic [31:0] QMAX_W      = 32'(QUEUE_DEPTH_MAX);

    typedef struct packed {
        logic [QSW-1:0] size;
        logic           ready;
        logic [63:0]    desc;
        logic [63:0]    avail;
        logic [63:0]    used;
    } qent_t;

    typedef enum logic {ST_IDLE, ST_EXEC} state_t;

    localparam qent_t QENT_RST = '{size: QSW'(QUEUE_DEPTH_MAX), ready: 1'b0,
                                   desc: 64'd0, avail: 64'd0, used: 64'd0};

    state_t            state_reg;
    logic              rsp_valid_reg;
    logic [31:0]       read_data_reg;
    logic              irq_level_reg;
    logic              notify_valid_reg;
    logic [2:0]        notify_queue_reg;

    logic [15:0]       device_kind_reg;
    logic [15:0]       vendor_code_reg;
    logic [31:0]       feature_word_reg;
    logic [8:0]        bytes_used_reg;
    logic [7:0]        manual_mask_reg;

    logic [31:0]       device_status_reg, device_status_next;
    logic [QW-1:0]     queue_select_reg, queue_select_next;
    logic [31:0]       feature_select_reg, feature_select_next;
    logic [1:0]        int_bits_reg, int_bits_next;
    logic [QUEUE_COUNT-1:0] qvalid_reg;

    logic [1:0]        act_reg;
    logic [11:0]       off_reg;
    logic [31:0]       wdata_reg;
    logic [1:0]        sz_reg;

    qent_t             qmem [QUEUE_COUNT];
    qent_t             q_rdata_reg;
    qent_t             q_cur;
    qent_t             q_wdata;
    logic              q_we;
    logic              q_clear;

    logic [7:0]        bank_rdata_reg [4];
    logic [3:0]        bank_rvld_reg;
    logic [7:0]        bank_wbyte [4];
    logic [3:0]        bank_we;

    logic              req_fire;
    logic              exec_go;
    logic [11:0]       at_in;
    logic [11:0]       at_reg;
    logic [12:0]       at_end;
    logic [8:0]        cfg_limit;
    logic [2:0]        nbytes;
    logic              cfg_fits;
    logic              is_cfg;
    logic [31:0]       rd_val;
    logic              note_v;
    logic [2:0]        note_q;
    logic [31:0]       reg_rd;
    logic [31:0]       cfg_rd;
    logic [1:0]        lane;
    logic [1:0]        ib;

    assign req_fire  = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign exec_go   = (state_reg == ST_EXEC) && (!rsp_valid_reg || !rsp_stall);
    assign cfg_ready = 1'b1;

    assign rsp_valid    = rsp_valid_reg;
    assign read_data    = read_data_reg;
    assign irq_level    = irq_level_reg;
    assign notify_valid = notify_valid_reg;
    assign notify_queue = notify_queue_reg;

    assign at_in     = offset - CFG_BASE;
    assign at_reg    = off_reg - CFG_BASE;
    assign is_cfg    = (off_reg >= CFG_BASE);
    assign cfg_limit = (bytes_used_reg > STORE_BYTES) ? STORE_BYTES : bytes_used_reg;
    assign nbytes    = 3'd1 << sz_reg;
    assign at_end    = {1'b0, at_reg} + 13'(nbytes);
    assign cfg_fits  = (sz_reg != SZ_NONE) && (at_end <= 13'(cfg_limit));
    assign q_cur     = qvalid_reg[queue_select_reg] ? q_rdata_reg : QENT_RST;

    // device config store: four byte lanes, each read at one row per request
    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [7:0]      cmem [ROWS];
        logic [ROWS-1:0] cvalid_reg;
        logic [RW-1:0]   rd_row;
        logic [RW-1:0]   wr_row;

        assign rd_row = (2'(b) >= at_in[1:0]) ? at_in[RW+1:2] : at_in[RW+1:2] + RW'(1);
        assign wr_row = (2'(b) >= at_reg[1:0]) ? at_reg[RW+1:2] : at_reg[RW+1:2] + RW'(1);

        always_ff @(posedge clk)
        begin
            if (req_fire)
            begin
                bank_rdata_reg[b] <= cmem[rd_row];
                bank_rvld_reg[b]  <= cvalid_reg[rd_row];
            end
            if (bank_we[b])
            begin
                cmem[wr_row] <= bank_wbyte[b];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cvalid_reg <= '0;
            end
            else if (bank_we[b])
            begin
                cvalid_reg[wr_row] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            act_reg     <= action;
            off_reg     <= offset;
            wdata_reg   <= wr_data;
            sz_reg      <= size_code;
            q_rdata_reg <= qmem[queue_select_reg];
        end
        if (q_we)
        begin
            qmem[queue_select_reg] <= q_wdata;
        end
    end

    // config byte lanes
    always_comb
    begin
        cfg_rd = '0;
        for (int i = 0; i < 4; i++)
        begin
            lane = at_reg[1:0] + 2'(i);
            if (3'(i) < nbytes && bank_rvld_reg[lane])
            begin
                cfg_rd[8*i +: 8] = bank_rdata_reg[lane];
            end
        end
        for (int b = 0; b < 4; b++)
        begin
            ib            = 2'(b) - at_reg[1:0];
            bank_wbyte[b] = wdata_reg[{ib, 3'b000} +: 8];
            bank_we[b]    = exec_go && (act_reg == ACT_WRITE) && is_cfg && cfg_fits
                            && (3'(ib) < nbytes);
        end
    end

    // register read decode
    always_comb
    begin
        unique case (off_reg)
            REG_MAGIC:       reg_rd = MAGIC_WORD;
            REG_VERSION:     reg_rd = VERSION_WORD;
            REG_DEVICE_ID:   reg_rd = {16'd0, device_kind_reg};
            REG_VENDOR_ID:   reg_rd = {16'd0, vendor_code_reg};
            REG_FEATURES:
            begin
                if (feature_select_reg == 32'd0)
                    reg_rd = feature_word_reg;
                else if (feature_select_reg == 32'd1)
                    reg_rd = 32'd1;
                else
                    reg_rd = 32'd0;
            end
            REG_FEAT_SEL:    reg_rd = feature_select_reg;
            REG_QUEUE_SEL:   reg_rd = 32'(queue_select_reg);
            REG_QUEUE_MAX:   reg_rd = QMAX_W;
            REG_QUEUE_NUM:   reg_rd = 32'(q_cur.size);
            REG_QUEUE_READY: reg_rd = {31'd0, q_cur.ready};
            REG_INT_STATUS:  reg_rd = {30'd0, int_bits_reg};
            REG_STATUS:      reg_rd = device_status_reg;
            REG_DESC_LO:     reg_rd = q_cur.desc[31:0];
            REG_DESC_HI:     reg_rd = q_cur.desc[63:32];
            REG_AVAIL_LO:    reg_rd = q_cur.avail[31:0];
            REG_AVAIL_HI:    reg_rd = q_cur.avail[63:32];
            REG_USED_LO:     reg_rd = q_cur.used[31:0];
            REG_USED_HI:     reg_rd = q_cur.used[63:32];
            default:         reg_rd = 32'd0;
        endcase
    end

    // read-modify-write step
    always_comb
    begin
        rd_val              = '0;
        note_v              = 1'b0;
        note_q              = '0;
        device_status_next  = device_status_reg;
        queue_select_next   = queue_select_reg;
        feature_select_next = feature_select_reg;
        int_bits_next       = int_bits_reg;
        q_wdata             = q_cur;
        q_we                = 1'b0;
        q_clear             = 1'b0;

        case (act_reg)
            ACT_READ:
            begin
                if (is_cfg)
                    rd_val = cfg_fits ? cfg_rd : 32'd0;
                else if (sz_reg == SZ_WORD)
                    rd_val = reg_rd;
            end
            ACT_WRITE:
            begin
                if (!is_cfg && sz_reg == SZ_WORD)
                begin
                    unique case (off_reg)
                        REG_FEAT_SEL:  feature_select_next = wdata_reg;
                        REG_QUEUE_SEL:
                        begin
                            if (wdata_reg < QCOUNT_W)
                                queue_select_next = wdata_reg[QW-1:0];
                        end
                        REG_QUEUE_NUM:
                        begin
                            if (wdata_reg != 32'd0 && (wdata_reg & (wdata_reg - 32'd1)) == 32'd0
                                && wdata_reg <= QMAX_W)
                            begin
                                q_wdata.size = wdata_reg[QSW-1:0];
                                q_we         = 1'b1;
                            end
                        end
                        REG_QUEUE_READY:
                        begin
                            q_wdata.ready = wdata_reg[0];
                            q_we          = 1'b1;
                        end
                        REG_NOTIFY:
                        begin
                            if (wdata_reg < QCOUNT_W
                                && !(wdata_reg < 32'd8 && manual_mask_reg[wdata_reg[2:0]]))
                            begin
                                note_v = 1'b1;
                                note_q = wdata_reg[2:0];
                            end
                        end
                        REG_INT_ACK:   int_bits_next = int_bits_reg & ~wdata_reg[1:0];
                        REG_STATUS:
                        begin
                            if (wdata_reg == 32'd0)
                            begin
                                device_status_next  = '0;
                                queue_select_next   = '0;
                                feature_select_next = '0;
                                int_bits_next       = '0;
                                q_clear             = 1'b1;
                            end
                            else
                            begin
                                device_status_next = wdata_reg;
                            end
                        end
                        REG_DESC_LO:
                        begin
                            q_wdata.desc[31:0] = wdata_reg;
                            q_we               = 1'b1;
                        end
                        REG_DESC_HI:
                        begin
                            q_wdata.desc[63:32] = wdata_reg;
                            q_we                = 1'b1;
                        end
                        REG_AVAIL_LO:
                        begin
                            q_wdata.avail[31:0] = wdata_reg;
                            q_we                = 1'b1;
                        end
                        REG_AVAIL_HI:
                        begin
                            q_wdata.avail[63:32] = wdata_reg;
                            q_we                 = 1'b1;
                        end
                        REG_USED_LO:
                        begin
                            q_wdata.used[31:0] = wdata_reg;
                            q_we               = 1'b1;
                        end
                        REG_USED_HI:
                        begin
                            q_wdata.used[63:32] = wdata_reg;
                            q_we                = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ACT_USED:       int_bits_next = int_bits_reg | 2'b01;
            default:        int_bits_next = int_bits_reg | 2'b10;
        endcase

        if (!exec_go)
        begin
            q_we    = 1'b0;
            q_clear = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            rsp_valid_reg      <= 1'b0;
            read_data_reg      <= '0;
            irq_level_reg      <= 1'b0;
            notify_valid_reg   <= 1'b0;
            notify_queue_reg   <= '0;
            device_kind_reg    <= DEVICE_KIND_RST;
            vendor_code_reg    <= VENDOR_CODE_RST;
            feature_word_reg   <= '0;
            bytes_used_reg     <= BYTES_USED_RST;
            manual_mask_reg    <= '0;
            device_status_reg  <= '0;
            queue_select_reg   <= '0;
            feature_select_reg <= '0;
            int_bits_reg       <= '0;
            qvalid_reg         <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DEVICE_KIND:  device_kind_reg  <= cfg_data[15:0];
                    CFG_VENDOR_CODE:  vendor_code_reg  <= cfg_data[15:0];
                    CFG_FEATURE_WORD: feature_word_reg <= cfg_data;
                    CFG_BYTES_USED:   bytes_used_reg   <= cfg_data[8:0];
                    CFG_MANUAL_MASK:  manual_mask_reg  <= cfg_data[7:0];
                    default: ;
                endcase
            end

            if (rsp_valid_reg && !rsp_stall && !exec_go)
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_fire)
                        state_reg <= ST_EXEC;
                end
                ST_EXEC:
                begin
                    if (exec_go)
                    begin
                        state_reg          <= ST_IDLE;
                        rsp_valid_reg      <= 1'b1;
                        read_data_reg      <= rd_val;
                        irq_level_reg      <= (int_bits_next != 2'b00);
                        notify_valid_reg   <= note_v;
                        notify_queue_reg   <= note_q;
                        device_status_reg  <= device_status_next;
                        queue_select_reg   <= queue_select_next;
                        feature_select_reg <= feature_select_next;
                        int_bits_reg       <= int_bits_next;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            if (q_clear)
                qvalid_reg <= '0;
            else if (q_we)
                qvalid_reg[queue_select_reg] <= 1'b1;
        end
    end

endmodule

`default_nettype wire

### bench/vmrf_response_checker.sv
// Response checker for the virtio MMIO register file: predicts each request's response and compares.
`timescale 1ns / 1ps

module vmrf_response_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_stall,
    input  logic [1:0]  action,
    input  logic [11:0] offset,
    input  logic [31:0] wr_data,
    input  logic [1:0]  size_code,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  logic [31:0] read_data,
    input  logic        irq_level,
    input  logic        notify_valid,
    input  logic [2:0]  notify_queue,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          error_count,
    output int          outstanding
);
    import vmrf_pkg::*;

    localparam int QUEUES      = QUEUE_COUNT_DEF;
    localparam int DEPTH_MAX   = QUEUE_DEPTH_MAX_DEF;
    localparam int STORE_BYTES = CONFIG_STORE_BYTES_DEF;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_level;
        logic        notify_valid;
        logic [2:0]  notify_queue;
    } response_t;

    logic [15:0] device_kind;
    logic [15:0] vendor_code;
    logic [31:0] feature_word;
    logic [8:0]  bytes_used;
    logic [7:0]  manual_mask;

    logic [31:0] dev_status;
    logic [31:0] feat_sel;
    logic [2:0]  qsel;
    logic [1:0]  irq_bits;
    logic        queue_ready [QUEUES];
    logic [4:0]  queue_size  [QUEUES];
    logic [63:0] desc_base   [QUEUES];
    logic [63:0] avail_base  [QUEUES];
    logic [63:0] used_base   [QUEUES];
    logic [7:0]  config_store [STORE_BYTES];

    response_t pending_responses [$];

    function automatic void reset_transport();
        dev_status = '0;
        qsel       = '0;
        feat_sel   = '0;
        irq_bits   = '0;
        for (int q = 0; q < QUEUES; q++)
        begin
            queue_ready[q] = 1'b0;
            queue_size[q]  = 5'(DEPTH_MAX);
            desc_base[q]   = '0;
            avail_base[q]  = '0;
            used_base[q]   = '0;
        end
    endfunction

    function automatic response_t predict_response(input logic [1:0] act,
                                                   input logic [11:0] off,
                                                   input logic [31:0] data,
                                                   input logic [1:0] sz);
        response_t rsp;
        int        at;
        int        width;
        int        window;
        int        q;
        logic      fits;
        rsp    = '0;
        q      = int'(qsel);
        at     = int'(off) - int'(CFG_BASE);
        width  = 1 << sz;
        window = (bytes_used > STORE_BYTES) ? STORE_BYTES : int'(bytes_used);
        // config window: whole access must lie below the valid byte count
        fits   = (sz != SZ_NONE) && (at + width <= window);
        case (act)
            ACT_READ:
            begin
                if (off >= CFG_BASE)
                begin
                    if (fits)
                        for (int i = 0; i < width; i++)
                            rsp.read_data[8*i +: 8] = config_store[at + i];
                end
                else if (sz == SZ_WORD)
                begin
                    case (off)
                        REG_MAGIC:       rsp.read_data = MAGIC_WORD;
                        REG_VERSION:     rsp.read_data = VERSION_WORD;
                        REG_DEVICE_ID:   rsp.read_data = 32'(device_kind);
                        REG_VENDOR_ID:   rsp.read_data = 32'(vendor_code);
                        REG_FEATURES:
                            if (feat_sel == 0)
                                rsp.read_data = feature_word;
                            else if (feat_sel == 1)
                                rsp.read_data = 32'd1;
                        REG_FEAT_SEL:    rsp.read_data = feat_sel;
                        REG_QUEUE_SEL:   rsp.read_data = 32'(qsel);
                        REG_QUEUE_MAX:   rsp.read_data = 32'(DEPTH_MAX);
                        REG_QUEUE_NUM:   rsp.read_data = 32'(queue_size[q]);
                        REG_QUEUE_READY: rsp.read_data = 32'(queue_ready[q]);
                        REG_INT_STATUS:  rsp.read_data = 32'(irq_bits);
                        REG_STATUS:      rsp.read_data = dev_status;
                        REG_DESC_LO:     rsp.read_data = desc_base[q][31:0];
                        REG_DESC_HI:     rsp.read_data = desc_base[q][63:32];
                        REG_AVAIL_LO:    rsp.read_data = avail_base[q][31:0];
                        REG_AVAIL_HI:    rsp.read_data = avail_base[q][63:32];
                        REG_USED_LO:     rsp.read_data = used_base[q][31:0];
                        REG_USED_HI:     rsp.read_data = used_base[q][63:32];
                        default:         rsp.read_data = '0;
                    endcase
                end
            end
            ACT_WRITE:
            begin
                if (off >= CFG_BASE)
                begin
                    if (fits)
                        for (int i = 0; i < width; i++)
                            config_store[at + i] = data[8*i +: 8];
                end
                else if (sz == SZ_WORD)
                begin
                    case (off)
                        REG_FEAT_SEL:    feat_sel = data;
                        REG_QUEUE_SEL:
                            if (data < QUEUES)
                                qsel = data[2:0];
                        REG_QUEUE_NUM:
                            if (data != 0 && (data & (data - 32'd1)) == 0 && data <= DEPTH_MAX)
                                queue_size[q] = data[4:0];
                        REG_QUEUE_READY: queue_ready[q] = data[0];
                        REG_NOTIFY:
                            if (data < QUEUES && !manual_mask[data[2:0]])
                            begin
                                rsp.notify_valid = 1'b1;
                                rsp.notify_queue = data[2:0];
                            end
                        REG_INT_ACK:     irq_bits = irq_bits & ~data[1:0];
                        REG_STATUS:
                            if (data == 0)
                                reset_transport();
                            else
                                dev_status = data;
                        REG_DESC_LO:     desc_base[q][31:0]   = data;
                        REG_DESC_HI:     desc_base[q][63:32]  = data;
                        REG_AVAIL_LO:    avail_base[q][31:0]  = data;
                        REG_AVAIL_HI:    avail_base[q][63:32] = data;
                        REG_USED_LO:     used_base[q][31:0]   = data;
                        REG_USED_HI:     used_base[q][63:32]  = data;
                        default:         ;
                    endcase
                end
            end
            ACT_USED:       irq_bits[0] = 1'b1;
            ACT_CFG_CHANGE: irq_bits[1] = 1'b1;
            default:        ;
        endcase
        rsp.irq_level = (irq_bits != 0);
        return rsp;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        response_t want;
        if (!rst_n)
        begin
            device_kind  = DEVICE_KIND_RST;
            vendor_code  = VENDOR_CODE_RST;
            feature_word = '0;
            bytes_used   = BYTES_USED_RST;
            manual_mask  = '0;
            reset_transport();
            foreach (config_store[i])
                config_store[i] = '0;
            pending_responses.delete();
            error_count = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_responses.size() == 0)
                begin
                    $display("%0t: response with no request pending, expected none, actual %h",
                             $time, read_data);
                    error_count++;
                end
                else
                begin
                    want = pending_responses.pop_front();
                    check_field("read_data", want.read_data, read_data);
                    check_field("irq_level", 32'(want.irq_level), 32'(irq_level));
                    check_field("notify_valid", 32'(want.notify_valid), 32'(notify_valid));
                    check_field("notify_queue", 32'(want.notify_queue), 32'(notify_queue));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DEVICE_KIND:  device_kind  = cfg_data[15:0];
                    CFG_VENDOR_CODE:  vendor_code  = cfg_data[15:0];
                    CFG_FEATURE_WORD: feature_word = cfg_data;
                    CFG_BYTES_USED:   bytes_used   = cfg_data[8:0];
                    CFG_MANUAL_MASK:  manual_mask  = cfg_data[7:0];
                    default:          ;
                endcase
            end
            if (req_valid && !req_stall)
                pending_responses.push_back(predict_response(action, offset, wr_data,
                                                             size_code));
        end
        outstanding = pending_responses.size();
    end

endmodule

### bench/tb_top.sv
// Testbench top for the virtio MMIO register file: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import vmrf_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic [1:0]  action;
    logic [11:0] offset;
    logic [31:0] wr_data;
    logic [1:0]  size_code;
    logic        rsp_valid;
    logic        rsp_stall;
    logic [31:0] read_data;
    logic        irq_level;
    logic        notify_valid;
    logic [2:0]  notify_queue;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    int errors;
    int in_flight;
    int gap_pct      = 20;
    int stall_pct    = 20;
    int window_bytes = 8;

    virtio_mmio_register_file uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .action       (action),
        .offset       (offset),
        .wr_data      (wr_data),
        .size_code    (size_code),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .read_data    (read_data),
        .irq_level    (irq_level),
        .notify_valid (notify_valid),
        .notify_queue (notify_queue),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    vmrf_response_checker response_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .action       (action),
        .offset       (offset),
        .wr_data      (wr_data),
        .size_code    (size_code),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .read_data    (read_data),
        .irq_level    (irq_level),
        .notify_valid (notify_valid),
        .notify_queue (notify_queue),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .error_count  (errors),
        .outstanding  (in_flight)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // entered and left at a falling edge with nothing yet driven in that step
    task automatic send_request(input logic [1:0] act, input logic [11:0] off,
                                input logic [31:0] data, input logic [1:0] sz);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        action     <= act;
        offset     <= off;
        wr_data    <= data;
        size_code  <= sz;
        req_valid  <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_request();
        int          pick;
        logic [1:0]  act;
        logic [11:0] off;
        logic [31:0] data;
        logic [1:0]  sz;
        pick = $urandom_range(99);
        data = $urandom;
        sz   = SZ_WORD;
        if (pick < 55)
        begin
            act = (pick < 30) ? ACT_READ : ACT_WRITE;
            case ($urandom_range(0, 19))
                0:       off = REG_MAGIC;
                1:       off = REG_VERSION;
                2:       off = REG_DEVICE_ID;
                3:       off = REG_VENDOR_ID;
                4:       off = REG_FEATURES;
                5:       off = REG_FEAT_SEL;
                6:       off = REG_QUEUE_SEL;
                7:       off = REG_QUEUE_MAX;
                8:       off = REG_QUEUE_NUM;
                9:       off = REG_QUEUE_READY;
                10:      off = REG_NOTIFY;
                11:      off = REG_INT_STATUS;
                12:      off = REG_INT_ACK;
                13:      off = REG_STATUS;
                14:      off = REG_DESC_LO;
                15:      off = REG_DESC_HI;
                16:      off = REG_AVAIL_LO;
                17:      off = REG_AVAIL_HI;
                18:      off = REG_USED_LO;
                default: off = REG_USED_HI;
            endcase
            case (off)
                REG_FEAT_SEL:
                    data = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2);
                REG_QUEUE_SEL:
                    data = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 9);
                REG_QUEUE_NUM:
                    data = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 33)
                                                       : (32'd1 << $urandom_range(0, 5));
                REG_NOTIFY:
                    data = $urandom_range(0, 9);
                REG_INT_ACK:
                    data = $urandom_range(0, 3);
                REG_STATUS:
                    data = ($urandom_range(0, 11) == 0) ? 32'd0 : $urandom;
                default:
                    ;
            endcase
        end
        else if (pick < 75)
        begin
            act = $urandom_range(0, 1) ? ACT_WRITE : ACT_READ;
            off = CFG_BASE + 12'($urandom_range(0, window_bytes + 4));
            sz  = ($urandom_range(0, 7) == 0) ? SZ_NONE : 2'($urandom_range(0, 2));
        end
        else if (pick < 85)
        begin
            act = $urandom_range(0, 1) ? ACT_USED : ACT_CFG_CHANGE;
            off = 12'($urandom);
            sz  = 2'($urandom);
        end
        else if (pick < 93)
        begin
            act = $urandom_range(0, 1) ? ACT_WRITE : ACT_READ;
            off = 12'($urandom_range(0, 255));
            sz  = 2'($urandom);
        end
        else
        begin
            act = 2'($urandom);
            off = 12'($urandom);
            sz  = 2'($urandom);
        end
        send_request(act, off, data, sz);
    endtask

    task automatic write_setting(input logic [2:0] idx, input logic [31:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        int waited;
        req_valid <= 1'b0;
        waited = 0;
        while (in_flight != 0 && waited < 2000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        rsp_stall = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_pct != 0 && $urandom_range(99) < stall_pct)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(negedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        logic [31:0] kind;
        logic [31:0] vendor;
        logic [31:0] features;
        logic [31:0] mask;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        action     = ACT_READ;
        offset     = '0;
        wr_data    = '0;
        size_code  = SZ_BYTE;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_DEVICE_KIND;
        cfg_data   = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: 8 config bytes, no manual queues
        send_request(ACT_READ,  REG_MAGIC,       32'd0,        SZ_WORD);
        send_request(ACT_READ,  REG_VERSION,     32'd0,        SZ_WORD);
        send_request(ACT_READ,  REG_DEVICE_ID,   32'd0,        SZ_WORD);
        send_request(ACT_READ,  REG_VENDOR_ID,   32'd0,        SZ_WORD);
        send_request(ACT_WRITE, REG_FEAT_SEL,    32'd1,        SZ_WORD);
        send_request(ACT_READ,  REG_FEATURES,    32'd0,        SZ_WORD);
        send_request(ACT_WRITE, REG_FEAT_SEL,    32'hffffffff, SZ_WORD);
        send_request(ACT_READ,  REG_FEATURES,    32'd0,        SZ_WORD);
        send_request(ACT_WRITE, REG_QUEUE_SEL,   32'd8,        SZ_WORD);
        send_request(ACT_WRITE, REG_QUEUE_SEL,   32'd7,        SZ_WORD);
        send_request(ACT_WRITE, REG_QUEUE_NUM,   32'd32,       SZ_WORD);
        send_request(ACT_WRITE, REG_QUEUE_NUM,   32'd3,        SZ_WORD);
        send_request(ACT_WRITE, REG_QUEUE_NUM,   32'd4,        SZ_WORD);
        send_request(ACT_READ,  REG_QUEUE_NUM,   32'd0,        SZ_WORD);
        send_request(ACT_WRITE, REG_DESC_HI,     32'hffffffff, SZ_WORD);
        send_request(ACT_READ,  REG_DESC_HI,     32'd0,        SZ_WORD);
        send_request(ACT_WRITE, REG_NOTIFY,      32'd7,        SZ_WORD);
        send_request(ACT_WRITE, REG_NOTIFY,      32'd8,        SZ_WORD);
        send_request(ACT_USED,  12'hfff,         32'hffffffff, SZ_NONE);
        send_request(ACT_CFG_CHANGE, 12'h000,    32'd0,        SZ_BYTE);
        send_request(ACT_WRITE, REG_INT_ACK,     32'd1,        SZ_WORD);
        send_request(ACT_WRITE, REG_STATUS,      32'd0,        SZ_WORD);
        send_request(ACT_WRITE, CFG_BASE + 12'd4, 32'hffffffff, SZ_WORD);
        send_request(ACT_READ,  CFG_BASE + 12'd6, 32'd0,       SZ_HALF);
        send_request(ACT_READ,  CFG_BASE + 12'd5, 32'd0,       SZ_WORD);
        send_request(ACT_WRITE, CFG_BASE,        32'h5a,       SZ_NONE);
        send_request(ACT_READ,  12'hfff,         32'd0,        SZ_BYTE);
        send_request(ACT_READ,  REG_MAGIC,       32'd0,        SZ_HALF);
        send_request(ACT_READ,  12'h0fc,         32'd0,        SZ_WORD);
        wait_idle();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    kind = 32'd0;
                    vendor = 32'd0;
                    features = 32'd0;
                    window_bytes = 0;
                    mask = 32'd0;
                    gap_pct = 20;
                    stall_pct = 25;
                end
                1:
                begin
                    kind = 32'hffff;
                    vendor = 32'hffff;
                    features = 32'hffffffff;
                    window_bytes = 256;
                    mask = 32'hff;
                    gap_pct = 35;
                    stall_pct = 15;
                end
                default:
                begin
                    kind = $urandom_range(0, 65535);
                    vendor = $urandom_range(0, 65535);
                    features = $urandom;
                    window_bytes = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(1, 40);
                    mask = $urandom_range(0, 255);
                    gap_pct = (phase == 5) ? 0 : $urandom_range(5, 40);
                    stall_pct = (phase == 5) ? 0 : $urandom_range(5, 40);
                end
            endcase
            write_setting(CFG_DEVICE_KIND, kind);
            write_setting(CFG_VENDOR_CODE, vendor);
            write_setting(CFG_FEATURE_WORD, features);
            write_setting(CFG_BYTES_USED, 32'(window_bytes));
            write_setting(CFG_MANUAL_MASK, mask);
            repeat (325)
                send_random_request();
            wait_idle();
        end

        if (errors == 0 && in_flight == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
sv/vmrf_pkg.sv
sv/virtio_mmio_register_file.sv
bench/vmrf_response_checker.sv
bench/tb_top.sv
